@@ rtl/core/ral_pkg.sv @@
`default_nettype none

package ral_pkg;

    localparam int ADDR_BITS   = 25;
    localparam int MAX_PENDING = 16;

    localparam int OFF_W = ADDR_BITS;
    localparam int SZ_W  = ADDR_BITS + 1;
    localparam int SUM_W = SZ_W + 1;
    localparam int IDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
    localparam int CNT_W = $clog2(MAX_PENDING + 1);

    localparam logic [SZ_W-1:0] CAP_MAX   = SZ_W'(1) << ADDR_BITS;
    localparam logic [SZ_W-1:0] CAP_RESET = SZ_W'(32 * 1024 * 1024);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load;          // capture input item
        logic mod_head;      // reduce head modulo capacity
        logic cons_rel;      // consume released section at head
        logic absorb;        // consume matched parked section
        logic head_wr;       // head <= modulo result
        logic alloc_prep;
        logic alloc_calc;
        logic match_en;
        logic match_key_off; // 1: key is release offset, 0: key is head
        logic park;
        logic fin;           // load output register, commit allocate
    } ral_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic cmd_rel;
        logic head_ok;
        logic head_hit;
        logic mod_done;
        logic match_any;
        logic out_free;
    } ral_sts_t;

    function automatic logic [SZ_W-1:0] eff_cap(input logic [SZ_W-1:0] c);
        logic [SZ_W-1:0] r;
        r = c;
        if (c == '0) r = SZ_W'(1);
        if (c > CAP_MAX) r = CAP_MAX;
        return r;
    endfunction

    // lowest set bit
    function automatic logic [IDX_W-1:0] first_set(input logic [MAX_PENDING-1:0] v);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = MAX_PENDING - 1; i >= 0; i--) begin
            if (v[i]) r = IDX_W'(i);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/ral_mod.sv @@
`default_nettype none

// a % cap: one compare for a < 2*cap, else restoring remainder, one bit per cycle
module ral_mod import ral_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] a,
    input  logic [SZ_W-1:0]  cap,
    output logic             done,
    output logic [OFF_W-1:0] rem
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    localparam logic [1:0] M_IDLE  = 2'd0;
    localparam logic [1:0] M_CHECK = 2'd1;
    localparam logic [1:0] M_ITER  = 2'd2;

    logic [1:0]        phase_reg, phase_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [SUM_W-1:0]  a_reg;
    logic [SZ_W-1:0]   cap_q;
    logic [OFF_W-1:0]  r_reg;

    logic [SZ_W-1:0]   shift_in;
    logic [SZ_W-1:0]   r_step;
    logic [SUM_W-1:0]  diff1;
    logic              fast0;
    logic              fast1;

    assign shift_in = {r_reg, a_reg[SUM_W-1]};
    assign r_step   = (shift_in >= cap_q) ? shift_in - cap_q : shift_in;
    assign diff1    = a_reg - SUM_W'(cap_q);
    assign fast0    = a_reg < SUM_W'(cap_q);
    assign fast1    = a_reg < {cap_q, 1'b0};

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        step_next  = step_reg;
        case (phase_reg)
            M_IDLE:
            begin
                if (start) phase_next = M_CHECK;
            end
            M_CHECK:
            begin
                if (fast0 || fast1) begin
                    phase_next = M_IDLE;
                    done_next  = 1'b1;
                end
                else begin
                    phase_next = M_ITER;
                    step_next  = STEP_W'(SUM_W);
                end
            end
            M_ITER:
            begin
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    phase_next = M_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                phase_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= M_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == M_IDLE && start) begin
            a_reg <= a;
            cap_q <= cap;
        end
        else if (phase_reg == M_CHECK) begin
            if (fast0)      r_reg <= a_reg[OFF_W-1:0];
            else if (fast1) r_reg <= diff1[OFF_W-1:0];
            else            r_reg <= '0;
        end
        else if (phase_reg == M_ITER) begin
            r_reg <= r_step[OFF_W-1:0];
            a_reg <= a_reg << 1;
        end
    end

    assign done = done_reg;
    assign rem  = r_reg;

    a_rem_below_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (SZ_W'(r_reg) < cap_q))
        else $error("remainder not below capacity");

endmodule

`default_nettype wire

@@ rtl/core/ral_table.sv @@
`default_nettype none

// parked release table: registered match vector, at most one write and one clear per cycle
module ral_table import ral_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             match_en,
    input  logic [OFF_W-1:0] key,
    input  logic             wr_en,
    input  logic [OFF_W-1:0] wr_off,
    input  logic [SZ_W-1:0]  wr_size,
    input  logic             clr_en,
    output logic             match_any,
    output logic             slot_ok,
    output logic [SZ_W-1:0]  rd_size
);

    logic [MAX_PENDING-1:0] valid_reg, valid_next;
    logic [MAX_PENDING-1:0] match_reg, match_next;
    logic [OFF_W-1:0]       off_mem  [MAX_PENDING];
    logic [SZ_W-1:0]        size_mem [MAX_PENDING];

    logic [IDX_W-1:0]       match_idx;
    logic [IDX_W-1:0]       free_idx;
    logic [IDX_W-1:0]       wr_idx;
    logic                   free_any;

    assign match_any = |match_reg;
    assign free_any  = |(~valid_reg);
    assign match_idx = first_set(match_reg);
    assign free_idx  = first_set(~valid_reg);
    // an existing entry at the same offset is overwritten
    assign wr_idx    = match_any ? match_idx : free_idx;
    assign slot_ok   = match_any || free_any;
    assign rd_size   = size_mem[match_idx];

    always_comb
    begin
        match_next = match_reg;
        if (match_en) begin
            for (int i = 0; i < MAX_PENDING; i++) begin
                match_next[i] = valid_reg[i] && (off_mem[i] == key);
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (clr_en) valid_next[match_idx] = 1'b0;
        if (wr_en && slot_ok) valid_next[wr_idx] = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
            match_reg <= '0;
        end
        else begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && slot_ok) begin
            off_mem[wr_idx]  <= wr_off;
            size_mem[wr_idx] <= wr_size;
        end
    end

    a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_reg))
        else $error("parked offset matched more than one entry");

    a_park_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && slot_ok && !clr_en) |=> valid_reg[$past(wr_idx)])
        else $error("parked entry not marked valid");

endmodule

`default_nettype wire

@@ rtl/core/ral_dp.sv @@
`default_nettype none

module ral_dp import ral_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [SZ_W-1:0]  cfg_wdata,
    input  logic             cmd,
    input  logic [SZ_W-1:0]  req_size,
    input  logic [OFF_W-1:0] rel_offset,
    input  logic [SZ_W-1:0]  rel_size,
    input  ral_cmd_t         ctl,
    output ral_sts_t         sts,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [OFF_W-1:0] grant_offset,
    output logic [SZ_W-1:0]  grant_size,
    output logic [SZ_W-1:0]  bytes_used
);

    logic             cmd_q;
    logic [SZ_W-1:0]  req_q;
    logic [OFF_W-1:0] off_q;
    logic [SZ_W-1:0]  rsize_q;

    logic [SZ_W-1:0]  cap_reg;
    logic [OFF_W-1:0] head_reg;
    logic [SZ_W-1:0]  used_reg;
    logic             full_reg;
    logic             out_valid_reg;

    logic [SZ_W-1:0]  freeb_reg;
    logic [SUM_W-1:0] tail_reg;
    logic [SZ_W-1:0]  alloc_reg;
    logic [OFF_W-1:0] goff_reg;

    logic [1:0]       status_reg;
    logic [OFF_W-1:0] gofs_out_reg;
    logic [SZ_W-1:0]  gsize_out_reg;
    logic [SZ_W-1:0]  used_out_reg;

    logic             mod_start;
    logic [SUM_W-1:0] mod_a;
    logic             mod_done;
    logic [OFF_W-1:0] mod_rem;

    logic             match_any;
    logic             slot_ok;
    logic [SZ_W-1:0]  pend_size;

    logic [SZ_W-1:0]  cons_size;
    logic [SUM_W-1:0] cons_sum;
    logic [SZ_W-1:0]  used_sub;

    logic [SZ_W-1:0]  freeb_next;
    logic [SUM_W-1:0] tail_next;
    logic [SZ_W-1:0]  alloc0;
    logic [SUM_W-1:0] room;
    logic             tail_in;
    logic [SUM_W-1:0] wrap_tail;
    logic [SZ_W-1:0]  alloc_next;
    logic [OFF_W-1:0] goff_next;

    logic [SZ_W-1:0]  alloc_eff;
    logic [SZ_W-1:0]  used_fin;
    logic [1:0]       status_fin;
    logic             is_rel;

    assign is_rel = (cmd_q == CMD_RELEASE);

    // consume path: release at head, or absorbed parked section
    assign cons_size = ctl.absorb ? pend_size : rsize_q;
    assign cons_sum  = SUM_W'(head_reg) + SUM_W'(cons_size);
    assign used_sub  = (cons_size >= used_reg) ? '0 : used_reg - cons_size;

    assign mod_start = ctl.mod_head || ctl.cons_rel || ctl.absorb;
    assign mod_a     = ctl.mod_head ? SUM_W'(head_reg) : cons_sum;

    // allocate, first step
    assign freeb_next = (used_reg >= cap_reg) ? '0 : cap_reg - used_reg;
    assign tail_next  = SUM_W'(head_reg) + SUM_W'(used_reg);

    // allocate, second step: never run past the end of the region
    assign alloc0     = (req_q < freeb_reg) ? req_q : freeb_reg;
    assign room       = SUM_W'(cap_reg) - tail_reg;
    assign tail_in    = tail_reg < SUM_W'(cap_reg);
    assign alloc_next = (tail_in && (SUM_W'(alloc0) > room)) ? room[SZ_W-1:0] : alloc0;
    assign wrap_tail  = tail_reg - SUM_W'(cap_reg);
    assign goff_next  = tail_in ? tail_reg[OFF_W-1:0] : wrap_tail[OFF_W-1:0];

    assign alloc_eff  = is_rel ? '0 : alloc_reg;
    assign used_fin   = used_reg + alloc_eff;

    always_comb
    begin
        if (is_rel)                status_fin = full_reg ? ST_FULL : ST_OK;
        else if (alloc_reg == '0)  status_fin = ST_NOSPACE;
        else                       status_fin = ST_OK;
    end

    ral_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .a     (mod_a),
        .cap   (cap_reg),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    ral_table u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .match_en  (ctl.match_en),
        .key       (ctl.match_key_off ? off_q : head_reg),
        .wr_en     (ctl.park),
        .wr_off    (off_q),
        .wr_size   (rsize_q),
        .clr_en    (ctl.absorb),
        .match_any (match_any),
        .slot_ok   (slot_ok),
        .rd_size   (pend_size)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg       <= eff_cap(CAP_RESET);
            head_reg      <= '0;
            used_reg      <= '0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (cfg_we) cap_reg <= eff_cap(cfg_wdata);
            if (ctl.head_wr) head_reg <= mod_rem;
            if (ctl.cons_rel || ctl.absorb) used_reg <= used_sub;
            else if (ctl.fin)                used_reg <= used_fin;
            if (ctl.load)                    full_reg <= 1'b0;
            else if (ctl.park && !slot_ok)   full_reg <= 1'b1;
            if (ctl.fin)                     out_valid_reg <= 1'b1;
            else if (out_ready)              out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load) begin
            cmd_q   <= cmd;
            req_q   <= req_size;
            off_q   <= rel_offset;
            rsize_q <= rel_size;
        end
        if (ctl.alloc_prep) begin
            freeb_reg <= freeb_next;
            tail_reg  <= tail_next;
        end
        if (ctl.alloc_calc) begin
            alloc_reg <= alloc_next;
            goff_reg  <= goff_next;
        end
        if (ctl.fin) begin
            status_reg    <= status_fin;
            gofs_out_reg  <= (alloc_eff != '0) ? goff_reg : '0;
            gsize_out_reg <= alloc_eff;
            used_out_reg  <= used_fin;
        end
    end

    assign sts.cmd_rel   = is_rel;
    assign sts.head_ok   = SZ_W'(head_reg) < cap_reg;
    assign sts.head_hit  = (off_q == head_reg);
    assign sts.mod_done  = mod_done;
    assign sts.match_any = match_any;
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign grant_offset = gofs_out_reg;
    assign grant_size   = gsize_out_reg;
    assign bytes_used   = used_out_reg;

endmodule

`default_nettype wire

@@ rtl/core/ral_ctrl.sv @@
`default_nettype none

module ral_ctrl import ral_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  ral_sts_t sts,
    output ral_cmd_t ctl
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_HWAIT = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_ALLOC = 4'd3;
    localparam logic [3:0] S_CWAIT = 4'd4;
    localparam logic [3:0] S_MATCH = 4'd5;
    localparam logic [3:0] S_CHAIN = 4'd6;
    localparam logic [3:0] S_PARK  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    ctl.load = 1'b1;
                    if (sts.head_ok) begin
                        state_next = S_DISP;
                    end
                    else begin
                        // capacity shrank since head was last moved
                        ctl.mod_head = 1'b1;
                        state_next   = S_HWAIT;
                    end
                end
            end
            S_HWAIT:
            begin
                if (sts.mod_done) begin
                    ctl.head_wr = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                ctl.alloc_prep = 1'b1;
                cnt_next       = '0;
                if (!sts.cmd_rel) begin
                    state_next = S_ALLOC;
                end
                else if (sts.head_hit) begin
                    ctl.cons_rel = 1'b1;
                    state_next   = S_CWAIT;
                end
                else begin
                    ctl.match_en      = 1'b1;
                    ctl.match_key_off = 1'b1;
                    state_next        = S_PARK;
                end
            end
            S_ALLOC:
            begin
                ctl.alloc_calc = 1'b1;
                state_next     = S_FIN;
            end
            S_CWAIT:
            begin
                if (sts.mod_done) begin
                    ctl.head_wr = 1'b1;
                    state_next  = S_MATCH;
                end
            end
            S_MATCH:
            begin
                ctl.match_en = 1'b1;
                state_next   = S_CHAIN;
            end
            S_CHAIN:
            begin
                if (sts.match_any && (cnt_reg != CNT_W'(MAX_PENDING))) begin
                    ctl.absorb = 1'b1;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_CWAIT;
                end
                else begin
                    state_next = S_FIN;
                end
            end
            S_PARK:
            begin
                ctl.park   = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (sts.out_free) begin
                    ctl.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        sts.mod_done |-> (state_reg == S_HWAIT || state_reg == S_CWAIT))
        else $error("modulo result arrived outside a wait state");

    a_chain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_PENDING))
        else $error("chain absorbed too many parked sections");

endmodule

`default_nettype wire

@@ rtl/core/ring_allocator_out_of_order_release.sv @@
`default_nettype none

// channel   handshake             payload
// -------   --------------------  ---------------------------------------------
// input     in_valid / in_ready   cmd, req_size, rel_offset, rel_size
// result    out_valid / out_ready status, grant_offset, grant_size, bytes_used
// config    cfg_we                cfg_wdata (capacity)
//
// Allocate runs through dispatch, allocate and the final state; release elsewhere
// through dispatch, park and final. Release at head moves the head through the
// modulo unit, then absorbs each parked section at the new head in the same way.
// The modulo unit ends on one compare, or one remainder bit per cycle when head
// plus size reaches twice the capacity. After a capacity change that leaves the head
// outside the region, the first item pays a modulo wait once more.
// Reset clears the parked-table valid bits at once; no clearing pass.
// A result waiting on out_ready does not block accepting the next item, whose
// result then waits in its final state.
module ring_allocator_out_of_order_release import ral_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [SZ_W-1:0]  cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             cmd,
    input  logic [SZ_W-1:0]  req_size,
    input  logic [OFF_W-1:0] rel_offset,
    input  logic [SZ_W-1:0]  rel_size,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       status,
    output logic [OFF_W-1:0] grant_offset,
    output logic [SZ_W-1:0]  grant_size,
    output logic [SZ_W-1:0]  bytes_used
);

    ral_cmd_t ctl;
    ral_sts_t sts;

    ral_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    ral_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd          (cmd),
        .req_size     (req_size),
        .rel_offset   (rel_offset),
        .rel_size     (rel_size),
        .ctl          (ctl),
        .sts          (sts),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .grant_offset (grant_offset),
        .grant_size   (grant_size),
        .bytes_used   (bytes_used)
    );

endmodule

`default_nettype wire
